@@ src/bal_pkg.sv @@
// Shared types, constants and codes for the bounded array list.
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

  localparam int Depth     = 16;
  localparam int DataWidth = 32;
  localparam int PosWidth  = $clog2(Depth);
  localparam int CntWidth  = $clog2(Depth + 1);
  localparam int ReqWidth  = 3;

  localparam logic [CntWidth-1:0] CapReset = CntWidth'(Depth);

  typedef enum logic [ReqWidth-1:0] {
    ReqPushBack  = 3'd0,
    ReqPushFront = 3'd1,
    ReqPopBack   = 3'd2,
    ReqPopFront  = 3'd3,
    ReqInsertAt  = 3'd4,
    ReqRemoveAt  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StEmpty  = 2'd2,
    StBadPos = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CtlIdle = 2'd0,
    CtlExec = 2'd1,
    CtlDone = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic [ReqWidth-1:0]         req_type;
    logic signed [DataWidth-1:0] value;
    logic [PosWidth-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] data_out;
    logic [1:0]                  status;
    logic [CntWidth-1:0]         count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

`default_nettype wire

@@ src/bal_ctrl.sv @@
// Controller state machine: accept, execute and answer one request.
`timescale 1ns / 1ps
`default_nettype none

module bal_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               valid_o,
  output bal_pkg::ctl_cmd_t  cmd_o
);
  import bal_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CtlIdle: begin
        if (start) state_d = CtlExec;
      end
      CtlExec: begin
        state_d = CtlDone;
      end
      CtlDone: begin
        state_d = start ? CtlExec : CtlIdle;
      end
      default: begin
        state_d = CtlIdle;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    valid_o    = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      CtlIdle: begin
        cmd_o.load = start;
      end
      CtlExec: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
      end
      CtlDone: begin
        valid_o    = 1'b1;
        cmd_o.load = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/bal_datapath.sv @@
// Datapath: entry registers with parallel shift, count, capacity and result register.
`timescale 1ns / 1ps
`default_nettype none

module bal_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bal_pkg::ctl_cmd_t             cmd_i,
  input  wire bal_pkg::req_t                 req_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bal_pkg::CntWidth-1:0]  cfg_wdata_i,
  output bal_pkg::rsp_t                      rsp_o
);
  import bal_pkg::*;

  req_t                 req_q;
  rsp_t                 rsp_q, rsp_d;
  logic [DataWidth-1:0] ent_q [Depth];
  logic [DataWidth-1:0] ent_d [Depth];
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [CntWidth-1:0]  cap_q;

  logic [CntWidth-1:0]  eff_cap;
  logic                 full, empty, is_ins, is_rem, ins_ok, rem_ok;
  logic [PosWidth-1:0]  ins_pos, rem_pos;
  logic [CntWidth-1:0]  pos_ext;
  status_e              status;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.exec) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < Depth; i++) ent_q[i] <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
      for (int i = 0; i < Depth; i++) ent_q[i] <= ent_d[i];
    end
  end

  always_comb begin
    eff_cap = (cap_q > CntWidth'(Depth)) ? CntWidth'(Depth) : cap_q;
    full    = cnt_q >= eff_cap;
    empty   = cnt_q == '0;
    pos_ext = {1'b0, req_q.position};
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    ins_pos = cnt_q[PosWidth-1:0];
    rem_pos = PosWidth'(cnt_q - CntWidth'(1));
    case (req_q.req_type)
      ReqPushBack: begin
        is_ins = 1'b1;
      end
      ReqPushFront: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      ReqInsertAt: begin
        is_ins  = 1'b1;
        ins_pos = req_q.position;
      end
      ReqPopBack: begin
        is_rem = 1'b1;
      end
      ReqPopFront: begin
        is_rem  = 1'b1;
        rem_pos = '0;
      end
      ReqRemoveAt: begin
        is_rem  = 1'b1;
        rem_pos = req_q.position;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  always_comb begin
    status = StOk;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    if (is_ins) begin
      if (full) begin
        status = StFull;
      end else if (req_q.req_type == ReqInsertAt && pos_ext > cnt_q) begin
        status = StBadPos;
      end else begin
        ins_ok = 1'b1;
      end
    end else if (is_rem) begin
      if (empty) begin
        status = StEmpty;
      end else if (req_q.req_type == ReqRemoveAt && pos_ext >= cnt_q) begin
        status = StBadPos;
      end else begin
        rem_ok = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ent_d[i] = ent_q[i];
      if (ins_ok) begin
        if (CntWidth'(i) == {1'b0, ins_pos}) begin
          ent_d[i] = req_q.value;
        end else if (i > 0 && CntWidth'(i) > {1'b0, ins_pos}) begin
          ent_d[i] = ent_q[(i > 0) ? i - 1 : 0];
        end
      end else if (rem_ok) begin
        if (CntWidth'(i) >= {1'b0, rem_pos}) begin
          ent_d[i] = (i == Depth - 1) ? '0 : ent_q[(i < Depth - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ins_ok) cnt_d = cnt_q + CntWidth'(1);
    else if (rem_ok) cnt_d = cnt_q - CntWidth'(1);

    rsp_d.status = status;
    rsp_d.count  = cnt_d;
    if (rem_ok) rsp_d.data_out = ent_q[rem_pos];
    else if (status != StOk) rsp_d.data_out = '1;
    else rsp_d.data_out = '0;
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

@@ src/bounded_array_list_top.sv @@
// Top level of the bounded array list: controller plus datapath.
// An accepted request executes, then its result beat is strobed in the done state.
// No request is taken while busy; start may be taken during the result beat.
// The receiver cannot stall; each result beat lasts exactly one cycle.
// Reset: list empty, all entries zero, capacity 16; asynchronous and active low.
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire bal_pkg::req_t                 req_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bal_pkg::CntWidth-1:0]  cfg_wdata_i,
  output logic                               valid_o,
  output bal_pkg::rsp_t                      rsp_o
);
  import bal_pkg::*;

  ctl_cmd_t cmd;

  bal_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  bal_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter execution");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (valid_o && !busy))
    else $error("execution did not produce a result beat");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rsp_o.count <= CntWidth'(Depth)))
    else $error("count beyond depth");

  a_fail_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status != StOk) |-> (rsp_o.data_out == '1))
    else $error("failed request without all-ones data");

endmodule

`default_nettype wire
